// ===== src/overwriting_bounded_deque_defines.svh =====
// Assertion macros shared by the deque checker.
`ifndef OVERWRITING_BOUNDED_DEQUE_DEFINES_SVH
`define OVERWRITING_BOUNDED_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OBDQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define OBDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ===== src/obdq_pkg.sv =====
// Shared constants, payload types and index helpers for the deque.
`default_nettype none

package obdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = IDX_W + 2;
    localparam int CAP_W      = 5;
    localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int OP_W       = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_PUSH_BACK = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CAPACITY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  pop_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                overwrote;
    } out_item_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } mem_req_t;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] r;
        r = sum;
        if (r >= SUM_W'(DEPTH))
        begin
            r = r - SUM_W'(DEPTH);
        end
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        if (CMP_W'(cap) > CMP_W'(DEPTH))
        begin
            return CNT_W'(DEPTH);
        end
        return CNT_W'(cap);
    endfunction

endpackage

`default_nettype wire

// ===== src/obdq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module obdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/obdq_ctrl.sv =====
// Sequencer that reads an end entry, applies the operation and writes back.
`default_nettype none

module obdq_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire obdq_pkg::in_item_t              in_data,
    input  wire logic [obdq_pkg::CAP_W-1:0]      capacity,
    input  wire logic [obdq_pkg::DATA_WIDTH-1:0] rdata,
    output obdq_pkg::mem_req_t                   mem_req,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output obdq_pkg::out_item_t                  res_data
);

    import obdq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic             state_reg, state_next;
    in_item_t         item_reg, item_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] raddr_reg, raddr_next;

    logic [CNT_W-1:0] cap;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] new_head;
    logic [CNT_W-1:0] new_count;
    logic             do_write;
    logic             take_data;
    logic             dropped;
    logic [STATUS_W-1:0] status;

    assign cap      = eff_cap(capacity);
    assign tail_idx = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg));
    assign last_idx = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1));
    assign head_inc = wrap_idx(SUM_W'(head_reg) + SUM_W'(1));

    always_comb
    begin
        new_head  = head_reg;
        new_count = count_reg;
        do_write  = 1'b0;
        take_data = 1'b0;
        dropped   = 1'b0;
        status    = ST_OK;
        case (item_reg.op)
            OP_PUSH_BACK:
            begin
                if (cap == '0)
                begin
                    status = ST_NO_CAPACITY;
                end
                else if (count_reg < cap)
                begin
                    do_write  = 1'b1;
                    new_count = count_reg + CNT_W'(1);
                end
                else
                begin
                    do_write  = 1'b1;
                    take_data = 1'b1;
                    dropped   = 1'b1;
                    new_head  = head_inc;
                end
            end
            OP_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    take_data = 1'b1;
                    new_head  = head_inc;
                    new_count = count_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    take_data = 1'b1;
                    new_count = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                new_head  = '0;
                new_count = '0;
            end
            default:
            begin
                new_head  = head_reg;
                new_count = count_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        head_next  = head_reg;
        count_next = count_reg;
        raddr_next = raddr_reg;
        res_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    raddr_next = (in_data.op == OP_POP_BACK) ? last_idx : head_reg;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    head_next  = new_head;
                    count_next = new_count;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign mem_req.we    = (state_reg == S_EXEC) && res_ready && do_write;
    assign mem_req.waddr = tail_idx;
    assign mem_req.wdata = DATA_WIDTH'(item_reg.push_value);
    assign mem_req.raddr = raddr_next;

    assign res_data.pop_value = take_data ? VALUE_W'(rdata) : '0;
    assign res_data.status    = status;
    assign res_data.count     = COUNT_W'(new_count);
    assign res_data.overwrote = dropped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        raddr_reg <= raddr_next;
    end

endmodule

`default_nettype wire

// ===== src/overwriting_bounded_deque.sv =====
// Top level of the overwriting bounded deque: capacity register, sequencer,
// entry memory and result register.
//
//   channel  direction  payload                                 handshake
//   cfg      in         capacity (5 bits)                       cfg_valid / cfg_ready
//   in       in         op, push_value                          in_valid / in_ready
//   out      out        pop_value, status, count, overwrote     out_valid / out_ready
//
// Each transaction first reads the end entry from the entry memory
// through its registered read port, then updates head and count and
// writes the memory back. A finished result sits in the output register, so
// the next transaction is taken while it waits. After reset the deque is
// empty and capacity is 16; no clearing pass is needed. A stalled output
// holds the sequencer in its update step until the result register frees.
`default_nettype none

module overwriting_bounded_deque (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [obdq_pkg::CAP_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire obdq_pkg::in_item_t         in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output obdq_pkg::out_item_t             out_data
);

    import obdq_pkg::*;

    logic [CAP_W-1:0]      capacity_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;
    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  res_valid;
    logic                  res_ready;
    out_item_t             res_data;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;

    obdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .capacity  (capacity_reg),
        .rdata     (rdata),
        .mem_req   (mem_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    obdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/obdq_checker.sv =====
// Port-level checker for the deque and the bind that attaches it.
`default_nettype none
`include "overwriting_bounded_deque_defines.svh"

module obdq_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire obdq_pkg::out_item_t out_data
);

    import obdq_pkg::*;

    `OBDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `OBDQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    `OBDQ_ASSERT_NOW(a_overwrite_ok, out_valid && out_data.overwrote, out_data.status == ST_OK)
    `OBDQ_ASSERT_NOW(a_fail_no_data, out_valid && out_data.status != ST_OK, out_data.pop_value == '0)

endmodule

bind overwriting_bounded_deque obdq_checker u_obdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
